### rtl/bgsg_pkg.sv
// bgsg_pkg: shared types, step labels and the control store for the box glyph
// segment generator; used by box_glyph_segment_generator_top
// no dependencies
`default_nettype none

package bgsg_pkg;

    localparam int GRID_STEPS_DEF = 60;

    // height/6 as multiply and shift, exact for 8-bit heights
    localparam logic [7:0] DIV6_MUL   = 8'd171;
    localparam int         DIV6_SHIFT = 10;

    localparam int PC_W = 4;

    // program step labels
    localparam logic [PC_W-1:0] STEP_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] STEP_LOOKUP  = 4'd1;
    localparam logic [PC_W-1:0] STEP_SX      = 4'd2;
    localparam logic [PC_W-1:0] STEP_SY      = 4'd3;
    localparam logic [PC_W-1:0] STEP_EX      = 4'd4;
    localparam logic [PC_W-1:0] STEP_EY      = 4'd5;
    localparam logic [PC_W-1:0] STEP_DRAIN0  = 4'd6;
    localparam logic [PC_W-1:0] STEP_DRAIN1  = 4'd7;
    localparam logic [PC_W-1:0] STEP_NOGLYPH = 4'd8;

    // configuration register indexes
    localparam logic [7:0] REG_CELL_WIDTH  = 8'd0;
    localparam logic [7:0] REG_CELL_HEIGHT = 8'd1;

    typedef enum logic [1:0] {
        COORD_SX,
        COORD_SY,
        COORD_EX,
        COORD_EY
    } coord_e_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_WAIT_START,
        COND_EMPTY,
        COND_MORE,
        COND_ALWAYS
    } cond_e_t;

    typedef struct packed {
        logic            accept;
        logic            load;
        logic            issue;
        coord_e_t        csel;
        logic            advance;
        logic            emit_none;
        cond_e_t         cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        bold;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
    } request_t;

    typedef struct packed {
        logic [12:0] start_x;
        logic [12:0] start_y;
        logic [12:0] end_x;
        logic [12:0] end_y;
        logic [5:0]  line_width;
        logic        segment_valid;
        logic        last;
    } result_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{accept: 1'b0, load: 1'b0, issue: 1'b0, csel: COORD_SX, advance: 1'b0,
              emit_none: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = COND_WAIT_START;
                w.target = STEP_IDLE;
            end
            STEP_LOOKUP:
            begin
                w.load   = 1'b1;
                w.cond   = COND_EMPTY;
                w.target = STEP_NOGLYPH;
            end
            STEP_SX:
            begin
                w.issue = 1'b1;
                w.csel  = COORD_SX;
                w.cond  = COND_NEXT;
            end
            STEP_SY:
            begin
                w.issue = 1'b1;
                w.csel  = COORD_SY;
                w.cond  = COND_NEXT;
            end
            STEP_EX:
            begin
                w.issue = 1'b1;
                w.csel  = COORD_EX;
                w.cond  = COND_NEXT;
            end
            STEP_EY:
            begin
                w.issue   = 1'b1;
                w.csel    = COORD_EY;
                w.advance = 1'b1;
                w.cond    = COND_MORE;
                w.target  = STEP_SX;
            end
            STEP_DRAIN0:
            begin
                w.cond = COND_NEXT;
            end
            STEP_DRAIN1:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            STEP_NOGLYPH:
            begin
                w.emit_none = 1'b1;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/box_glyph_segment_generator_top.sv
// box_glyph_segment_generator_top: microcoded sequencer that turns a line-drawing
// character into scaled line segments; depends on bgsg_pkg
//
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+--------------------------
// request   | in        | start high while busy low  | request_t
// result    | out       | result_strobe, one cycle   | result_t
// cfg       | in        | cfg_valid and cfg_ready    | cfg_index, cfg_data
//
// sequence: after the accepting edge busy stays high through the lookup step, one
// coordinate a cycle through the shared scaling pipeline, then two drain steps
// for its two stages ahead of the result register; an item with no glyph keeps
// busy high through the lookup and the no-glyph step
// results: one per segment of a glyph, the final one shown in the cycle in
// which busy falls
// reset: asynchronous, clears the step counter, the pipeline valids and the
// strobe; cell registers come up as 8 by 16
// the receiver cannot stall, so the result register is simply overwritten
// per segment; cfg_ready is always high
`default_nettype none

module box_glyph_segment_generator_top
    import bgsg_pkg::*;
#(
    parameter int GRID_STEPS = GRID_STEPS_DEF
)
(
    input  wire        clk,
    input  wire        rst_n,

    input  wire        start,
    output logic       busy,
    input  wire request_t request,

    output result_t    result,
    output logic       result_strobe,

    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [7:0] cfg_index,
    input  wire  [7:0] cfg_data
);

    // grid points of the glyph table, worked out from the grid size
    localparam logic [7:0] GZ  = 8'd0;
    localparam logic [7:0] GF  = 8'(GRID_STEPS);
    localparam logic [7:0] MD  = 8'(GRID_STEPS / 2);
    localparam logic [7:0] G4  = 8'(GRID_STEPS / 4);
    localparam logic [7:0] G34 = 8'(3 * GRID_STEPS / 4);
    localparam logic [7:0] G3  = 8'(GRID_STEPS / 3);
    localparam logic [7:0] G23 = 8'(2 * GRID_STEPS / 3);
    localparam logic [7:0] G38 = 8'(3 * GRID_STEPS / 8);
    localparam logic [7:0] G6  = 8'(GRID_STEPS / 6);
    localparam logic [7:0] G56 = 8'(5 * GRID_STEPS / 6);
    localparam logic [7:0] G5  = 8'(GRID_STEPS / 5);

    // divide by (grid - 1) as multiply by a rounded-up reciprocal and shift;
    // exact for every 16-bit product of grid point and cell span
    localparam int              DIV      = GRID_STEPS - 1;
    localparam int              PROD_W   = 16;
    localparam int              SHIFT    = PROD_W + $clog2(DIV);
    localparam longint unsigned RECIP_L  = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [16:0]     RECIP    = 17'(RECIP_L);

    localparam int SEG_N = 44;

    // x0, y0, x1, y1 per segment
    localparam logic [7:0] SEG_TBL [SEG_N][4] = '{
        // diamond
        '{MD, G4, G34, MD}, '{G34, MD, MD, G34},
        '{MD, G34, G4, MD}, '{G4, MD, MD, G4},
        '{MD, G3, G23, MD}, '{G23, MD, MD, G23},
        '{MD, G23, G3, MD}, '{G3, MD, MD, G3},
        '{G4, MD, G34, MD}, '{MD, G4, MD, G34},
        // degrees
        '{MD, G4, G23, G38}, '{G23, G38, MD, MD},
        '{MD, MD, G3, G38}, '{G3, G38, MD, G4},
        // lower right corner
        '{GZ, MD, MD, MD}, '{MD, MD, MD, GZ},
        // upper right corner
        '{GZ, MD, MD, MD}, '{MD, MD, MD, GF},
        // upper left corner
        '{MD, MD, GF, MD}, '{MD, MD, MD, GF},
        // lower left corner
        '{MD, GZ, MD, MD}, '{MD, MD, GF, MD},
        // cross
        '{GZ, MD, GF, MD}, '{MD, GZ, MD, GF},
        // scan lines
        '{GZ, GZ, GF, GZ},
        '{GZ, G4, GF, G4},
        '{GZ, MD, GF, MD},
        '{GZ, G34, GF, G34},
        // horizontal line
        '{GZ, GF, GF, GF},
        // left tee
        '{MD, GZ, MD, GF}, '{MD, MD, GF, MD},
        // right tee
        '{MD, GZ, MD, GF}, '{MD, MD, GZ, MD},
        // bottom tee
        '{GZ, MD, GF, MD}, '{MD, GZ, MD, MD},
        // top tee
        '{GZ, MD, GF, MD}, '{MD, MD, MD, GF},
        // vertical line
        '{MD, GZ, MD, GF},
        // less than or equal
        '{G56, G6, G5, MD}, '{G56, G56, G5, MD},
        '{G6, G56, G56, G56},
        // greater than or equal
        '{G6, G6, G56, MD}, '{G6, G56, G56, MD},
        '{G6, G56, G56, G56}
    };

    // first segment and segment count for each code below 32
    localparam logic [5:0] GLYPH_FIRST [32] = '{
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd10,
        6'd0,  6'd0,  6'd0,  6'd14, 6'd16, 6'd18, 6'd20, 6'd22,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd31, 6'd33,
        6'd35, 6'd37, 6'd38, 6'd41, 6'd0,  6'd0,  6'd0,  6'd0
    };
    localparam logic [3:0] GLYPH_COUNT [32] = '{
        4'd0, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd4,
        4'd0, 4'd0,  4'd0, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd1, 4'd1,  4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd1,  4'd3, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0
    };

    // configuration
    logic [7:0] cell_width_reg;
    logic [7:0] cell_height_reg;

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uc;

    // item context
    request_t   req_reg;
    logic [5:0] ptr_reg;
    logic [3:0] remain_reg;
    logic [5:0] lw_reg;

    // scaling pipeline; a full-grid point on a wide cell scales past 255
    logic [15:0] a_prod_reg;
    coord_e_t    a_csel_reg;
    logic        a_last_reg;
    logic        a_vld_reg;
    logic [8:0]  b_q_reg;
    coord_e_t    b_csel_reg;
    logic        b_last_reg;
    logic        b_vld_reg;

    // output
    result_t result_reg;
    logic    strobe_reg;

    logic [5:0]  look_first;
    logic [3:0]  look_count;
    logic [15:0] h_mul;
    logic [5:0]  lw_calc;
    logic [7:0]  grid_pt;
    logic [7:0]  span;
    logic [7:0]  w_span;
    logic [7:0]  h_span;
    logic [32:0] b_full;
    logic [12:0] c_sum;

    assign uc        = ucode_rom(pc_reg);
    assign busy      = (pc_reg != STEP_IDLE);
    assign cfg_ready = 1'b1;

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    // config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= 8'd8;
            cell_height_reg <= 8'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data;
                REG_CELL_HEIGHT: cell_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // glyph lookup; codes from 32 up have nothing
    always_comb
    begin
        if (req_reg.char_code[7:5] == 3'd0)
        begin
            look_first = GLYPH_FIRST[req_reg.char_code[4:0]];
            look_count = GLYPH_COUNT[req_reg.char_code[4:0]];
        end
        else
        begin
            look_first = 6'd0;
            look_count = 4'd0;
        end
    end

    // line thickness: height/6 bold, height/8 plain, at least 1
    assign h_mul = 16'(cell_height_reg) * 16'(DIV6_MUL);
    always_comb
    begin
        if (req_reg.bold)
            lw_calc = (cell_height_reg > 8'd6) ? h_mul[DIV6_SHIFT +: 6] : 6'd1;
        else
            lw_calc = (cell_height_reg > 8'd8) ? {1'b0, cell_height_reg[7:3]} : 6'd1;
    end

    // step counter and conditional jumps
    always_comb
    begin
        pc_next = pc_reg + 4'd1;
        unique case (uc.cond)
            COND_NEXT:       pc_next = pc_reg + 4'd1;
            COND_WAIT_START: pc_next = start ? pc_reg + 4'd1 : uc.target;
            COND_EMPTY:      pc_next = (look_count == 4'd0) ? uc.target : pc_reg + 4'd1;
            COND_MORE:       pc_next = (remain_reg > 4'd1) ? uc.target : pc_reg + 4'd1;
            COND_ALWAYS:     pc_next = uc.target;
            default:         pc_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

    // item context
    always_ff @(posedge clk)
    begin
        if (uc.accept && start)
            req_reg <= request;
        if (uc.load)
        begin
            ptr_reg    <= look_first;
            remain_reg <= look_count;
            lw_reg     <= lw_calc;
        end
        else if (uc.advance)
        begin
            ptr_reg    <= ptr_reg + 6'd1;
            remain_reg <= remain_reg - 4'd1;
        end
    end

    // stage a: grid point times cell span
    assign w_span  = (cell_width_reg  != 8'd0) ? cell_width_reg  - 8'd1 : 8'd0;
    assign h_span  = (cell_height_reg != 8'd0) ? cell_height_reg - 8'd1 : 8'd0;
    assign grid_pt = SEG_TBL[ptr_reg][uc.csel];
    assign span    = (uc.csel == COORD_SX || uc.csel == COORD_EX) ? w_span : h_span;

    // stage b: reciprocal multiply for the truncating divide
    assign b_full = 33'(a_prod_reg) * 33'(RECIP);

    // stage c: add the origin of the matching axis
    assign c_sum = (b_csel_reg == COORD_SX || b_csel_reg == COORD_EX)
                 ? 13'(req_reg.origin_x) + 13'(b_q_reg)
                 : 13'(req_reg.origin_y) + 13'(b_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg  <= uc.issue;
            b_vld_reg  <= a_vld_reg;
            strobe_reg <= uc.emit_none || (b_vld_reg && b_csel_reg == COORD_EY);
        end
    end

    always_ff @(posedge clk)
    begin
        a_prod_reg <= 16'(grid_pt) * 16'(span);
        a_csel_reg <= uc.csel;
        a_last_reg <= (remain_reg == 4'd1);
        b_q_reg    <= b_full[SHIFT +: 9];
        b_csel_reg <= a_csel_reg;
        b_last_reg <= a_last_reg;

        if (uc.emit_none)
        begin
            result_reg.start_x       <= 13'd0;
            result_reg.start_y       <= 13'd0;
            result_reg.end_x         <= 13'd0;
            result_reg.end_y         <= 13'd0;
            result_reg.line_width    <= lw_reg;
            result_reg.segment_valid <= 1'b0;
            result_reg.last          <= 1'b1;
        end
        else if (b_vld_reg)
        begin
            case (b_csel_reg)
                COORD_SX: result_reg.start_x <= c_sum;
                COORD_SY: result_reg.start_y <= c_sum;
                COORD_EX: result_reg.end_x   <= c_sum;
                default:
                begin
                    result_reg.end_y         <= c_sum;
                    result_reg.line_width    <= lw_reg;
                    result_reg.segment_valid <= 1'b1;
                    result_reg.last          <= b_last_reg;
                end
            endcase
        end
    end

    // a result only ever follows a cycle inside an item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result strobe outside an item");

    // coordinates are issued only while the sequencer runs
    assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg |-> busy)
        else $error("coordinate in flight while idle");

    // the final coordinate of a segment in stage a passes through stage b and then shows on the result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_vld_reg && a_csel_reg == COORD_EY) |-> ##2 result_strobe)
        else $error("segment not delivered");

    // an empty result always closes the character
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.segment_valid) |-> result.last)
        else $error("empty result without last");

    // thickness is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (result.line_width != 6'd0))
        else $error("zero line width");

endmodule

`default_nettype wire

### sim/tb_top.sv
// tb_top: self-checking bench for box_glyph_segment_generator_top, predicting every
// segment of each glyph and comparing it on the result strobe
// depends on bgsg_pkg and box_glyph_segment_generator_top

module tb_top;
    import bgsg_pkg::*;

    // grid positions used by the segment table, derived from the grid size
    localparam int         GS = GRID_STEPS_DEF;
    localparam logic [7:0] GF = 8'(GS);
    localparam logic [7:0] MD = 8'(GS / 2);
    localparam logic [7:0] Q1 = 8'(GS / 4);
    localparam logic [7:0] Q3 = 8'(3 * GS / 4);
    localparam logic [7:0] T1 = 8'(GS / 3);
    localparam logic [7:0] T2 = 8'(2 * GS / 3);
    localparam logic [7:0] E3 = 8'(3 * GS / 8);
    localparam logic [7:0] S1 = 8'(GS / 6);
    localparam logic [7:0] S5 = 8'(5 * GS / 6);
    localparam logic [7:0] F1 = 8'(GS / 5);

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 46;

    // holds the segments still owed by the block, oldest first
    class glyph_segment_tracker;
        logic [7:0] cell_w;
        logic [7:0] cell_h;
        result_t    owed_segments[$];
        int         mismatches;

        function new();
            cell_w     = 8'd8;
            cell_h     = 8'd16;
            mismatches = 0;
        endfunction

        function void set_cells(input logic [7:0] w, input logic [7:0] h);
            cell_w = w;
            cell_h = h;
        endfunction

        function int pending();
            return owed_segments.size();
        endfunction

        // first table row and number of segments for a code, 0 segments when no glyph
        static function logic [15:0] glyph_span(input logic [7:0] code);
            case (code)
                8'd1:    return {8'd0, 8'd10};
                8'd7:    return {8'd10, 8'd4};
                8'd11:   return {8'd14, 8'd2};
                8'd12:   return {8'd16, 8'd2};
                8'd13:   return {8'd18, 8'd2};
                8'd14:   return {8'd20, 8'd2};
                8'd15:   return {8'd22, 8'd2};
                8'd16:   return {8'd24, 8'd1};
                8'd17:   return {8'd25, 8'd1};
                8'd18:   return {8'd26, 8'd1};
                8'd19:   return {8'd27, 8'd1};
                8'd20:   return {8'd28, 8'd1};
                8'd21:   return {8'd29, 8'd2};
                8'd22:   return {8'd31, 8'd2};
                8'd23:   return {8'd33, 8'd2};
                8'd24:   return {8'd35, 8'd2};
                8'd25:   return {8'd37, 8'd1};
                8'd26:   return {8'd38, 8'd3};
                8'd27:   return {8'd41, 8'd3};
                default: return 16'd0;
            endcase
        endfunction

        // grid endpoints x0, y0, x1, y1 of one table row
        static function logic [31:0] grid_row(input int idx);
            case (idx)
                0:       return {MD, Q1, Q3, MD};
                1:       return {Q3, MD, MD, Q3};
                2:       return {MD, Q3, Q1, MD};
                3:       return {Q1, MD, MD, Q1};
                4:       return {MD, T1, T2, MD};
                5:       return {T2, MD, MD, T2};
                6:       return {MD, T2, T1, MD};
                7:       return {T1, MD, MD, T1};
                8:       return {Q1, MD, Q3, MD};
                9:       return {MD, Q1, MD, Q3};
                10:      return {MD, Q1, T2, E3};
                11:      return {T2, E3, MD, MD};
                12:      return {MD, MD, T1, E3};
                13:      return {T1, E3, MD, Q1};
                14:      return {8'd0, MD, MD, MD};
                15:      return {MD, MD, MD, 8'd0};
                16:      return {8'd0, MD, MD, MD};
                17:      return {MD, MD, MD, GF};
                18:      return {MD, MD, GF, MD};
                19:      return {MD, MD, MD, GF};
                20:      return {MD, 8'd0, MD, MD};
                21:      return {MD, MD, GF, MD};
                22:      return {8'd0, MD, GF, MD};
                23:      return {MD, 8'd0, MD, GF};
                24:      return {8'd0, 8'd0, GF, 8'd0};
                25:      return {8'd0, Q1, GF, Q1};
                26:      return {8'd0, MD, GF, MD};
                27:      return {8'd0, Q3, GF, Q3};
                28:      return {8'd0, GF, GF, GF};
                29:      return {MD, 8'd0, MD, GF};
                30:      return {MD, MD, GF, MD};
                31:      return {MD, 8'd0, MD, GF};
                32:      return {MD, MD, 8'd0, MD};
                33:      return {8'd0, MD, GF, MD};
                34:      return {MD, 8'd0, MD, MD};
                35:      return {8'd0, MD, GF, MD};
                36:      return {MD, MD, MD, GF};
                37:      return {MD, 8'd0, MD, GF};
                38:      return {S5, S1, F1, MD};
                39:      return {S5, S5, F1, MD};
                40:      return {S1, S5, S5, S5};
                41:      return {S1, S1, S5, MD};
                42:      return {S1, S5, S5, MD};
                43:      return {S1, S5, S5, S5};
                default: return 32'd0;
            endcase
        endfunction

        // origin plus grid step scaled by (size - 1) / (steps - 1), size 0 as span 0
        static function logic [12:0] place(input logic [11:0] origin, input logic [7:0] n,
                                           input logic [7:0] size);
            int span;
            span = (size > 0) ? int'(size) - 1 : 0;
            return 13'(int'(origin) + (int'(n) * span) / (GS - 1));
        endfunction

        function void note_glyph(input request_t req);
            logic [15:0] span;
            logic [31:0] row;
            logic [5:0]  thick;
            result_t     seg;
            int          n;
            if (req.bold)
                thick = 6'((cell_h > 8'd6) ? cell_h / 8'd6 : 8'd1);
            else
                thick = 6'((cell_h > 8'd8) ? cell_h / 8'd8 : 8'd1);
            span = glyph_span(req.char_code);
            if (span[7:0] == 8'd0)
            begin
                // no glyph: one empty result that still carries the width
                seg               = '0;
                seg.line_width    = thick;
                seg.last          = 1'b1;
                owed_segments.push_back(seg);
            end
            else
            begin
                for (n = 0; n < int'(span[7:0]); n++)
                begin
                    row               = grid_row(int'(span[15:8]) + n);
                    seg.start_x       = place(req.origin_x, row[31:24], cell_w);
                    seg.start_y       = place(req.origin_y, row[23:16], cell_h);
                    seg.end_x         = place(req.origin_x, row[15:8], cell_w);
                    seg.end_y         = place(req.origin_y, row[7:0], cell_h);
                    seg.line_width    = thick;
                    seg.segment_valid = 1'b1;
                    seg.last          = (n + 1 == int'(span[7:0]));
                    owed_segments.push_back(seg);
                end
            end
        endfunction

        function void compare_field(input string label, input int want, input int got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, label, want, got);
            end
        endfunction

        function void check_segment(input result_t got);
            result_t want;
            if (owed_segments.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = owed_segments.pop_front();
            compare_field("start_x", want.start_x, got.start_x);
            compare_field("start_y", want.start_y, got.start_y);
            compare_field("end_x", want.end_x, got.end_x);
            compare_field("end_y", want.end_y, got.end_y);
            compare_field("line_width", want.line_width, got.line_width);
            compare_field("segment_valid", want.segment_valid, got.segment_valid);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    request_t   request;
    result_t    result;
    logic       result_strobe;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    glyph_segment_tracker tracker;
    bit                   calm_phase;
    int                   cycle_count;

    // codes for the opening directed run: every glyph, some empty table slots
    // and codes beyond the table
    logic [7:0] opening_codes [24] = '{
        8'd1, 8'd7, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18,
        8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27,
        8'd0, 8'd2, 8'd31, 8'd32, 8'd255
    };

    // cell sizes per random phase: the extremes, zero sizes, then a few ordinary ones
    logic [7:0] phase_w [RANDOM_PHASES] = '{
        8'd255, 8'd1, 8'd0, 8'd0, 8'd255, 8'd2, 8'd60, 8'd0, 8'd0, 8'd0
    };
    logic [7:0] phase_h [RANDOM_PHASES] = '{
        8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd6, 8'd48, 8'd0, 8'd0, 8'd0
    };

    box_glyph_segment_generator_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 unit clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // results cannot be held off, so every strobe is checked at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            tracker.check_segment(result);
    end

    // mostly short gaps, now and then a long one; calm phases run back to back
    function automatic int pick_gap();
        int roll;
        if (calm_phase)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one item, hold it until the block takes it, then idle for a gap
    task automatic send_glyph(input request_t req);
        int gap;
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        tracker.note_glyph(req);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering items until every owed segment has come back
    task automatic wait_for_segments();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both cell registers, valid held high across the pair
    task automatic write_cells(input logic [7:0] w, input logic [7:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= REG_CELL_WIDTH;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= REG_CELL_HEIGHT;
        cfg_data  <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_cells(w, h);
    endtask

    // mostly table codes, a share forced onto real glyphs, the rest anywhere above
    function automatic request_t random_glyph();
        request_t req;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            req.char_code = 8'($urandom_range(0, 31));
        else if (roll < 85)
        begin
            req.char_code = 8'($urandom_range(0, 31));
            while (glyph_segment_tracker::glyph_span(req.char_code) == 16'd0)
                req.char_code = 8'($urandom_range(0, 31));
        end
        else
            req.char_code = 8'($urandom_range(32, 255));
        req.bold = 1'($urandom);
        roll = $urandom_range(0, 9);
        req.origin_x = (roll == 0) ? 12'd0 : (roll == 1) ? 12'hFFF : 12'($urandom);
        roll = $urandom_range(0, 9);
        req.origin_y = (roll == 0) ? 12'd0 : (roll == 1) ? 12'hFFF : 12'($urandom);
        return req;
    endfunction

    // watchdog: generous bound on the whole run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL box_glyph_segment_generator_top");
        $finish;
    end

    initial
    begin
        request_t req;
        int       p;
        int       k;
        tracker    = new();
        calm_phase = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_CELL_WIDTH;
        cfg_data   = 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed run at the reset cell size of 8 by 16, origins at both extremes
        for (k = 0; k < 24; k++)
        begin
            req.char_code = opening_codes[k];
            req.bold      = 1'(k);
            req.origin_x  = (k % 3 == 0) ? 12'hFFF : 12'd0;
            req.origin_y  = (k % 4 < 2) ? 12'd0 : 12'hFFF;
            send_glyph(req);
        end
        wait_for_segments();

        // random phases, each under its own cell size, written while the block is idle
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p >= 7)
                write_cells(8'($urandom), 8'($urandom));
            else
                write_cells(phase_w[p], phase_h[p]);
            calm_phase = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                send_glyph(random_glyph());
                // occasional full drain in the middle of a phase
                if ($urandom_range(0, 39) == 0)
                    wait_for_segments();
            end
            wait_for_segments();
        end

        // everything delivered; allow the pipeline drain before judging
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("PASS box_glyph_segment_generator_top");
        else
            $display("FAIL box_glyph_segment_generator_top");
        $finish;
    end

endmodule
